@@ sv/idgs_pkg.sv @@
package idgs_pkg;

    // graph sizing
    localparam int NODE_COUNT = 64;
    localparam int MAX_DEGREE = 8;
    localparam int MAX_DEPTH  = 63;

    // fixed field widths of the words on the channels
    localparam int CMD_W         = 2;
    localparam int NODE_W        = 6;
    localparam int SLOT_IDX_W    = 3;
    localparam int DEG_W         = 4;
    localparam int LIM_IN_W      = 6;
    localparam int FOUND_LIMIT_W = 6;

    // derived internal widths
    localparam int NODE_AW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SLOT_W    = $clog2(MAX_DEGREE + 1);
    localparam int LIMIT_W   = $clog2(MAX_DEPTH + 1);
    localparam int SP_W      = $clog2(MAX_DEPTH + 2);
    localparam int STK_DEPTH = MAX_DEPTH + 1;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int ADJ_DEPTH = NODE_COUNT * MAX_DEGREE;
    localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
    localparam int FRAME_W   = NODE_W + SLOT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SLOT   = 2'd0,
        CMD_DEGREE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } idgs_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS_INIT,
        ST_DEG_WAIT,
        ST_STEP,
        ST_NB_WAIT,
        ST_POP_WAIT
    } idgs_state_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SLOT_W-1:0] slot;
    } idgs_frame_t;

    typedef struct packed {
        logic              adj_we;
        logic [ADJ_AW-1:0] adj_addr;
        logic [NODE_W-1:0] adj_wdata;
        logic              deg_we;
        logic [NODE_AW-1:0] deg_addr;
        logic [SLOT_W-1:0] deg_wdata;
        logic              stk_we;
        logic [STK_AW-1:0] stk_addr;
        idgs_frame_t       stk_wdata;
    } idgs_mem_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] adj_rdata;
        logic [SLOT_W-1:0] deg_rdata;
        idgs_frame_t       stk_rdata;
    } idgs_mem_rsp_t;

endpackage

@@ sv/idgs_cmd_if.sv @@
interface idgs_cmd_if;
    import idgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [NODE_W-1:0]     node_index;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [NODE_W-1:0]     neighbor_node;
    logic [DEG_W-1:0]      degree_count;
    logic [NODE_W-1:0]     target_node;
    logic [LIM_IN_W-1:0]   depth_limit;

    modport source (
        output valid, cmd, node_index, slot_index, neighbor_node,
               degree_count, target_node, depth_limit,
        input  ready
    );

    modport sink (
        input  valid, cmd, node_index, slot_index, neighbor_node,
               degree_count, target_node, depth_limit,
        output ready
    );

endinterface

@@ sv/idgs_res_if.sv @@
interface idgs_res_if;
    import idgs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [FOUND_LIMIT_W-1:0] found_limit;

    modport source (
        output valid, found, found_limit,
        input  ready
    );

    modport sink (
        input  valid, found, found_limit,
        output ready
    );

endinterface

@@ sv/idgs_ram.sv @@
module idgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/idgs_ctrl.sv @@
module idgs_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    idgs_cmd_if.sink                req,
    idgs_res_if.source              rsp,
    output idgs_pkg::idgs_mem_req_t mem_req,
    input  idgs_pkg::idgs_mem_rsp_t mem_rsp
);
    import idgs_pkg::*;

    idgs_state_t state_reg, state_next;

    logic [NODE_W-1:0]        start_reg, start_next;
    logic [NODE_W-1:0]        target_reg, target_next;
    logic [LIMIT_W-1:0]       limit_reg, limit_next;
    logic [LIMIT_W-1:0]       pass_reg, pass_next;
    logic [NODE_W-1:0]        cur_node_reg, cur_node_next;
    logic [SLOT_W-1:0]        cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]        cur_deg_reg, cur_deg_next;
    logic [SP_W-1:0]          sp_reg, sp_next;
    logic [NODE_COUNT-1:0]    visited_reg, visited_next;
    logic                     res_valid_reg, res_valid_next;
    logic                     res_found_reg, res_found_next;
    logic [FOUND_LIMIT_W-1:0] res_limit_reg, res_limit_next;

    logic               accept;
    logic               start_hit;
    logic               start_ok;
    logic               exhausted;
    logic               slot_done;
    logic               last_pass;
    logic [NODE_W-1:0]  nb;
    logic               nb_ok;
    logic               nb_seen;
    logic               can_push;
    logic [SLOT_W-1:0]  deg_sat;
    logic [LIMIT_W-1:0] lim_sat;
    logic [SP_W-1:0]    sp_minus1;
    logic [SP_W-1:0]    sp_minus2;

    assign req.ready = (state_reg == ST_IDLE) && (!res_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = res_valid_reg;
    assign rsp.found       = res_found_reg;
    assign rsp.found_limit = res_limit_reg;

    assign start_hit = (start_reg == target_reg);
    assign start_ok  = 32'(start_reg) < NODE_COUNT;
    // remaining depth below one once the frame depth reaches the limit
    assign exhausted = 32'(sp_reg) > 32'(pass_reg);
    assign slot_done = cur_slot_reg >= cur_deg_reg;
    assign last_pass = (pass_reg == limit_reg);
    assign nb        = mem_rsp.adj_rdata;
    assign nb_ok     = 32'(nb) < NODE_COUNT;
    assign nb_seen   = nb_ok && visited_reg[NODE_AW'(nb)];
    assign can_push  = 32'(sp_reg) <= MAX_DEPTH;
    assign sp_minus1 = sp_reg - SP_W'(1);
    assign sp_minus2 = sp_reg - SP_W'(2);

    assign deg_sat = (32'(req.degree_count) > MAX_DEGREE) ? SLOT_W'(MAX_DEGREE)
                                                          : SLOT_W'(req.degree_count);
    assign lim_sat = (32'(req.depth_limit) > MAX_DEPTH) ? LIMIT_W'(MAX_DEPTH)
                                                        : LIMIT_W'(req.depth_limit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_SEARCH))
                begin
                    state_next = ST_PASS_INIT;
                end
            end
            ST_PASS_INIT:
            begin
                if (start_hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (!start_ok)
                begin
                    state_next = last_pass ? ST_IDLE : ST_PASS_INIT;
                end
                else
                begin
                    state_next = ST_DEG_WAIT;
                end
            end
            ST_DEG_WAIT:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (exhausted || slot_done)
                begin
                    if (sp_reg == SP_W'(1))
                    begin
                        state_next = last_pass ? ST_IDLE : ST_PASS_INIT;
                    end
                    else
                    begin
                        state_next = ST_POP_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_NB_WAIT;
                end
            end
            ST_NB_WAIT:
            begin
                if (!nb_ok || nb_seen)
                begin
                    state_next = ST_STEP;
                end
                else if (nb == target_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!can_push)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    state_next = ST_DEG_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_DEG_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        start_next     = start_reg;
        target_next    = target_reg;
        limit_next     = limit_reg;
        pass_next      = pass_reg;
        cur_node_next  = cur_node_reg;
        cur_slot_next  = cur_slot_reg;
        cur_deg_next   = cur_deg_reg;
        sp_next        = sp_reg;
        visited_next   = visited_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_found_next = res_found_reg;
        res_limit_next = res_limit_reg;

        mem_req.adj_we    = 1'b0;
        mem_req.adj_addr  = ADJ_AW'(cur_node_reg) * ADJ_AW'(MAX_DEGREE)
                            + ADJ_AW'(cur_slot_reg);
        mem_req.adj_wdata = req.neighbor_node;
        mem_req.deg_we    = 1'b0;
        mem_req.deg_addr  = NODE_AW'(req.node_index);
        mem_req.deg_wdata = deg_sat;
        mem_req.stk_we    = 1'b0;
        mem_req.stk_addr  = sp_minus2[STK_AW-1:0];
        mem_req.stk_wdata = '{node: cur_node_reg, slot: cur_slot_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.adj_addr = ADJ_AW'(req.node_index) * ADJ_AW'(MAX_DEGREE)
                                   + ADJ_AW'(req.slot_index);
                if (accept)
                begin
                    case (req.cmd)
                        CMD_SLOT:
                        begin
                            mem_req.adj_we = (32'(req.node_index) < NODE_COUNT)
                                          && (32'(req.slot_index) < MAX_DEGREE);
                        end
                        CMD_DEGREE:
                        begin
                            mem_req.deg_we = 32'(req.node_index) < NODE_COUNT;
                        end
                        CMD_SEARCH:
                        begin
                            start_next  = req.node_index;
                            target_next = req.target_node;
                            limit_next  = lim_sat;
                            pass_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PASS_INIT:
            begin
                visited_next     = '0;
                mem_req.deg_addr = NODE_AW'(start_reg);
                if (start_hit)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = 1'b1;
                    res_limit_next = FOUND_LIMIT_W'(pass_reg);
                end
                else if (!start_ok)
                begin
                    if (last_pass)
                    begin
                        res_valid_next = 1'b1;
                        res_found_next = 1'b0;
                        res_limit_next = '0;
                    end
                    else
                    begin
                        pass_next = pass_reg + LIMIT_W'(1);
                    end
                end
                else
                begin
                    visited_next[NODE_AW'(start_reg)] = 1'b1;
                    cur_node_next = start_reg;
                    cur_slot_next = '0;
                    sp_next       = SP_W'(1);
                end
            end
            ST_DEG_WAIT:
            begin
                cur_deg_next = mem_rsp.deg_rdata;
            end
            ST_STEP:
            begin
                if (exhausted || slot_done)
                begin
                    sp_next = sp_minus1;
                    if (sp_reg == SP_W'(1))
                    begin
                        if (last_pass)
                        begin
                            res_valid_next = 1'b1;
                            res_found_next = 1'b0;
                            res_limit_next = '0;
                        end
                        else
                        begin
                            pass_next = pass_reg + LIMIT_W'(1);
                        end
                    end
                end
                else
                begin
                    // neighbour read issued at the current slot
                    cur_slot_next = cur_slot_reg + SLOT_W'(1);
                end
            end
            ST_NB_WAIT:
            begin
                mem_req.deg_addr = NODE_AW'(nb);
                mem_req.stk_addr = sp_minus1[STK_AW-1:0];
                if (nb_ok && !nb_seen)
                begin
                    if (nb == target_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_found_next = 1'b1;
                        res_limit_next = FOUND_LIMIT_W'(pass_reg);
                    end
                    else
                    begin
                        visited_next[NODE_AW'(nb)] = 1'b1;
                        if (can_push)
                        begin
                            // parent frame goes to the stack, child becomes top
                            mem_req.stk_we = 1'b1;
                            cur_node_next  = nb;
                            cur_slot_next  = '0;
                            sp_next        = sp_reg + SP_W'(1);
                        end
                    end
                end
            end
            ST_POP_WAIT:
            begin
                cur_node_next    = mem_rsp.stk_rdata.node;
                cur_slot_next    = mem_rsp.stk_rdata.slot;
                mem_req.deg_addr = NODE_AW'(mem_rsp.stk_rdata.node);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            sp_reg        <= '0;
            pass_reg      <= '0;
            limit_reg     <= '0;
            visited_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            sp_reg        <= sp_next;
            pass_reg      <= pass_next;
            limit_reg     <= limit_next;
            visited_reg   <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        target_reg    <= target_next;
        cur_node_reg  <= cur_node_next;
        cur_slot_reg  <= cur_slot_next;
        cur_deg_reg   <= cur_deg_next;
        res_found_reg <= res_found_next;
        res_limit_reg <= res_limit_next;
    end

`ifndef NO_ASSERTIONS
    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pass_reg <= limit_reg))
        else $error("pass counter beyond depth limit");

    a_sp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |->
            (sp_reg != '0) && (32'(sp_reg) <= 32'(pass_reg) + 1))
        else $error("frame depth beyond current limit");

    a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEG_WAIT) |-> visited_reg[NODE_AW'(cur_node_reg)])
        else $error("top frame node not marked visited");

    a_miss_limit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_found_reg) |-> (res_limit_reg == '0))
        else $error("miss reported with non-zero limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !rsp.ready) |=> res_valid_reg)
        else $error("pending result dropped");
`endif

endmodule

@@ sv/iterative_deepening_graph_search.sv @@
// Iterative deepening graph search.
// req carries load and search words, rsp carries one result word per search.
// cmd 0 writes a neighbour slot, cmd 1 a node degree (saturated), cmd 3 is
// dropped; these give no result, so loads stream at one word a cycle while
// the block is idle and no result waits on a stalled receiver. cmd 2 runs
// passes for limits 0 up to depth_limit and answers with found and the
// limit of the first successful pass. A search holds req.ready low for its
// whole walk. Each pass starts from the start node and reads a degree for
// each frame entered, the adjacency for each neighbour slot tried and the
// stack for each frame left, all through the single-port adjacency, degree
// and frame memories. How long a search runs depends on the data: it is
// shortest when start equals target and longest when every pass walks
// every slot of a fully loaded graph. The result sits in an output
// register; req.ready stays low while a result waits and the receiver
// stalls, so at most one result is ever pending. Reset clears the degree
// valid bits (degrees read as zero), the visited map and the controller;
// adjacency slots stay undefined until written. There is no clearing pass;
// req.ready is high straight out of reset.
module iterative_deepening_graph_search (
    input  logic        clk,
    input  logic        rst_n,
    idgs_cmd_if.sink    req,
    idgs_res_if.source  rsp
);
    import idgs_pkg::*;

    idgs_mem_req_t mem_req;
    idgs_mem_rsp_t mem_rsp;

    logic [NODE_COUNT-1:0] deg_valid_reg;
    logic                  deg_hit_reg;
    logic [SLOT_W-1:0]     deg_raw;
    logic [FRAME_W-1:0]    stk_raw;

    idgs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    idgs_ram #(.WIDTH(NODE_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .clk   (clk),
        .we    (mem_req.adj_we),
        .addr  (mem_req.adj_addr),
        .wdata (mem_req.adj_wdata),
        .rdata (mem_rsp.adj_rdata)
    );

    idgs_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_COUNT)) u_deg_ram (
        .clk   (clk),
        .we    (mem_req.deg_we),
        .addr  (mem_req.deg_addr),
        .wdata (mem_req.deg_wdata),
        .rdata (deg_raw)
    );

    idgs_ram #(.WIDTH(FRAME_W), .DEPTH(STK_DEPTH)) u_stk_ram (
        .clk   (clk),
        .we    (mem_req.stk_we),
        .addr  (mem_req.stk_addr),
        .wdata (mem_req.stk_wdata),
        .rdata (stk_raw)
    );

    // an unwritten degree reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_valid_reg <= '0;
            deg_hit_reg   <= 1'b0;
        end
        else
        begin
            deg_hit_reg <= deg_valid_reg[mem_req.deg_addr];
            if (mem_req.deg_we)
            begin
                deg_valid_reg[mem_req.deg_addr] <= 1'b1;
            end
        end
    end

    assign mem_rsp.deg_rdata = deg_hit_reg ? deg_raw : '0;
    assign mem_rsp.stk_rdata = stk_raw;

endmodule
